>>> design/silu_bwd_pkg.sv
`default_nettype none

package silu_bwd_pkg;

  localparam int unsigned DataWidthDef      = 16;
  localparam int unsigned SigTableDepthDef  = 256;
  localparam int unsigned FracBits          = 12;
  localparam int unsigned GainWidth         = 16;
  localparam int unsigned CfgAddrW          = 1;
  localparam int unsigned SigW              = 17;   // Q1.16, 65536 = 1.0
  localparam int unsigned WideW             = 80;

  localparam logic [GainWidth-1:0] AlphaGainRst = 16'd4096;
  localparam logic [GainWidth-1:0] BetaGainRst  = 16'd0;

  localparam logic signed [WideW-1:0] WOne   = 80'sd1;
  localparam logic [63:0]             ExpM1Q30 = 64'd395007542;  // e^-1 in Q30
  localparam logic [63:0]             Mask30   = 64'h3FFF_FFFF;

  typedef enum logic [CfgAddrW-1:0] {
    CfgAlphaGain = 1'b0,
    CfgBetaGain  = 1'b1
  } cfg_reg_e;

  // round to nearest, ties up, then arithmetic shift
  function automatic logic signed [WideW-1:0] rnd_shr(input logic signed [WideW-1:0] v,
                                                      input int unsigned sh);
    logic signed [WideW-1:0] half;
    half = WOne <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [WideW-1:0] sat_to(input logic signed [WideW-1:0] v,
                                                     input int unsigned w);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = (WOne <<< (w - 1)) - WOne;
    lo = -hi - WOne;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // shift-subtract divide, only used when building the sigmoid table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f, f in [0,1) as Q30, series through the 24th-order term
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * f) >> 30, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // sigmoid(-8 + 16k/depth) in Q0.16
  function automatic logic [SigW-1:0] sig_entry(input int unsigned k, input int unsigned depth);
    longint      d;
    logic [63:0] ad;
    logic [63:0] a;
    logic [63:0] ip;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] sp;
    d  = 16 * longint'(k) - 8 * longint'(depth);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    a  = udiv64(ad << 30, 64'(depth));
    ip = a >> 30;
    e  = exp_neg_frac(a & Mask30);
    for (int i = 0; i < 9; i++) begin
      if (64'(i) < ip) begin
        e = (e * ExpM1Q30 + (64'd1 << 29)) >> 30;
      end
    end
    den = (64'd1 << 30) + e;
    sp  = udiv64((64'd1 << 46) + (den >> 1), den);
    return (d < 0) ? SigW'(64'd65536 - sp) : SigW'(sp);
  endfunction

endpackage

`default_nettype wire

>>> design/silu_backward_scaled_accumulate_unit.sv
// SiLU backward with scaled accumulation, one item per element.
// 9 register stages from input handshake to result valid.
// Throughput: one item per cycle; each stage holds on its own when the output stalls.
// Sigmoid table is constant logic, so there is no fill or clearing pass after reset.
// Reset: alpha_gain = 1.0, beta_gain = 0, all pipeline valid bits cleared.
`default_nettype none

module silu_backward_scaled_accumulate_unit #(
  parameter int unsigned DATA_WIDTH          = silu_bwd_pkg::DataWidthDef,
  parameter int unsigned SIGMOID_TABLE_DEPTH = silu_bwd_pkg::SigTableDepthDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // config
  input  wire logic                                   cfg_we_i,
  input  wire logic [silu_bwd_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [silu_bwd_pkg::GainWidth-1:0]     cfg_wdata_i,
  // input items
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // x_value, grad_out, prev_grad, zero pad
  input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  input  wire logic                                   s_axis_tlast_i,
  // result items
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // grad_in, zero pad
  output logic [((DATA_WIDTH+7)/8)*8-1:0]             m_axis_tdata_o,
  output logic                                        m_axis_tlast_o
);

  import silu_bwd_pkg::*;

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned Depth  = SIGMOID_TABLE_DEPTH;
  localparam int unsigned OutTdW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned NStg   = 9;
  localparam int unsigned UW     = ((DW > 16) ? DW : 16) + 2;
  localparam int unsigned PW     = 16 + $clog2(Depth + 1);
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned RomAw  = $clog2(Depth + 1);
  localparam int unsigned PrW    = DW + GainWidth;
  localparam int unsigned M1W    = DW + 18;
  localparam int unsigned TW     = ((DW + 5 > 18) ? DW + 5 : 18) + 1;
  localparam int unsigned StW    = 18 + TW;

  localparam logic signed [UW-1:0] SigOffset = UW'(8 << FracBits);

  // ---------------- configuration ----------------
  logic signed [GainWidth-1:0] alpha_q;
  logic signed [GainWidth-1:0] beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaGainRst;
      beta_q  <= BetaGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgAlphaGain: alpha_q <= cfg_wdata_i;
        CfgBetaGain:  beta_q  <= cfg_wdata_i;
      endcase
    end
  end

  // ---------------- sigmoid table ----------------
  logic [SigW-1:0] sig_rom [Depth+1];

  for (genvar k = 0; k <= Depth; k++) begin : g_rom
    localparam logic [SigW-1:0] RomEntry = sig_entry(k, Depth);
    assign sig_rom[k] = RomEntry;
  end

  // ---------------- pipeline control ----------------
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] vld_d;
  logic [NStg:0]   rdy;

  always_comb begin
    rdy[NStg] = m_axis_tready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid_i : vld_q[(k == 0) ? 0 : k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = rdy[0];

  // ---------------- stage 1: table address, gain products ----------------
  logic signed [DW-1:0] in_x;
  logic signed [DW-1:0] in_dy;
  logic signed [DW-1:0] in_prev;
  logic signed [UW-1:0] u_s;
  logic [PW-1:0]        pos;

  assign in_x    = s_axis_tdata_i[DW-1:0];
  assign in_dy   = s_axis_tdata_i[2*DW-1:DW];
  assign in_prev = s_axis_tdata_i[3*DW-1:2*DW];
  assign u_s     = {{(UW-DW){in_x[DW-1]}}, in_x} + SigOffset;
  assign pos     = PW'(u_s[15:0]) * PW'(Depth);

  logic signed [DW-1:0]  s1_x_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic [15:0]           s1_fr_q;
  logic                  s1_below_q;
  logic                  s1_above_q;
  logic signed [PrW-1:0] s1_pa_q;
  logic signed [PrW-1:0] s1_pb_q;
  logic                  s1_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_x_q     <= in_x;
      s1_idx_q   <= pos[16 +: IdxW];
      s1_fr_q    <= pos[15:0];
      s1_below_q <= u_s[UW-1];
      s1_above_q <= !u_s[UW-1] && (u_s[UW-2:16] != '0);
      s1_pa_q    <= PrW'(alpha_q) * PrW'(in_dy);
      s1_pb_q    <= PrW'(beta_q) * PrW'(in_prev);
      s1_last_q  <= s_axis_tlast_i;
    end
  end

  // ---------------- stage 2: table read, gain rounding ----------------
  logic [SigW-1:0] rom_lo;
  logic [SigW-1:0] rom_hi;

  assign rom_lo = sig_rom[RomAw'(s1_idx_q)];
  assign rom_hi = sig_rom[RomAw'(s1_idx_q) + RomAw'(1)];

  logic [SigW-1:0]      s2_lo_q;
  logic [SigW-1:0]      s2_hi_q;
  logic [15:0]          s2_fr_q;
  logic                 s2_below_q;
  logic                 s2_above_q;
  logic signed [DW-1:0] s2_x_q;
  logic signed [DW-1:0] s2_p_q;
  logic signed [DW-1:0] s2_b_q;
  logic                 s2_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_lo_q    <= rom_lo;
      s2_hi_q    <= (rom_hi < rom_lo) ? rom_lo : rom_hi;
      s2_fr_q    <= s1_fr_q;
      s2_below_q <= s1_below_q;
      s2_above_q <= s1_above_q;
      s2_x_q     <= s1_x_q;
      s2_p_q     <= DW'(sat_to(rnd_shr(WideW'(s1_pa_q), FracBits), DW));
      s2_b_q     <= DW'(sat_to(rnd_shr(WideW'(s1_pb_q), FracBits), DW));
      s2_last_q  <= s1_last_q;
    end
  end

  // ---------------- stage 3: interpolation ----------------
  logic [33:0]     interp_prod;
  logic [SigW-1:0] s_interp;

  assign interp_prod = 34'(s2_hi_q - s2_lo_q) * 34'(s2_fr_q) + 34'h8000;
  assign s_interp    = s2_lo_q + SigW'(interp_prod >> 16);

  logic [SigW-1:0]      s3_s_q;
  logic signed [DW-1:0] s3_x_q;
  logic signed [DW-1:0] s3_p_q;
  logic signed [DW-1:0] s3_b_q;
  logic                 s3_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      if (s2_below_q) begin
        s3_s_q <= '0;
      end else if (s2_above_q) begin
        s3_s_q <= SigW'(65536);
      end else begin
        s3_s_q <= s_interp;
      end
      s3_x_q    <= s2_x_q;
      s3_p_q    <= s2_p_q;
      s3_b_q    <= s2_b_q;
      s3_last_q <= s2_last_q;
    end
  end

  // ---------------- stage 4: x * (1 - s) ----------------
  logic signed [17:0] one_m_s;

  assign one_m_s = $signed({1'b0, SigW'(SigW'(65536) - s3_s_q)});

  logic signed [M1W-1:0] s4_m1_q;
  logic [SigW-1:0]       s4_s_q;
  logic signed [DW-1:0]  s4_p_q;
  logic signed [DW-1:0]  s4_b_q;
  logic                  s4_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_m1_q   <= M1W'(s3_x_q) * M1W'(one_m_s);
      s4_s_q    <= s3_s_q;
      s4_p_q    <= s3_p_q;
      s4_b_q    <= s3_b_q;
      s4_last_q <= s3_last_q;
    end
  end

  // ---------------- stage 5: t = 1 + x*(1-s) ----------------
  logic signed [TW-1:0] s5_t_q;
  logic [SigW-1:0]      s5_s_q;
  logic signed [DW-1:0] s5_p_q;
  logic signed [DW-1:0] s5_b_q;
  logic                 s5_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_t_q    <= TW'(rnd_shr(WideW'(s4_m1_q), FracBits)) + TW'(65536);
      s5_s_q    <= s4_s_q;
      s5_p_q    <= s4_p_q;
      s5_b_q    <= s4_b_q;
      s5_last_q <= s4_last_q;
    end
  end

  // ---------------- stage 6: s * t ----------------
  logic signed [17:0] s_sgn;

  assign s_sgn = $signed({1'b0, s5_s_q});

  logic signed [StW-1:0] s6_st_q;
  logic signed [DW-1:0]  s6_p_q;
  logic signed [DW-1:0]  s6_b_q;
  logic                  s6_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_st_q   <= StW'(s_sgn) * StW'(s5_t_q);
      s6_p_q    <= s5_p_q;
      s6_b_q    <= s5_b_q;
      s6_last_q <= s5_last_q;
    end
  end

  // ---------------- stage 7: g, back to Q12 ----------------
  logic signed [DW-1:0] s7_g_q;
  logic signed [DW-1:0] s7_p_q;
  logic signed [DW-1:0] s7_b_q;
  logic                 s7_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_g_q    <= DW'(sat_to(rnd_shr(WideW'(s6_st_q), 20), DW));
      s7_p_q    <= s6_p_q;
      s7_b_q    <= s6_b_q;
      s7_last_q <= s6_last_q;
    end
  end

  // ---------------- stage 8: p * g ----------------
  logic signed [2*DW-1:0] s8_pg_q;
  logic signed [DW-1:0]   s8_b_q;
  logic                   s8_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_pg_q   <= (2*DW)'(s7_p_q) * (2*DW)'(s7_g_q);
      s8_b_q    <= s7_b_q;
      s8_last_q <= s7_last_q;
    end
  end

  // ---------------- stage 9: round, accumulate, output register ----------------
  logic signed [WideW-1:0] c_new;
  logic signed [WideW-1:0] c_acc;

  always_comb begin
    c_new = sat_to(rnd_shr(WideW'(s8_pg_q), FracBits), DW);
    // previous gradient only enters when beta is non-zero
    if (beta_q != '0) begin
      c_acc = sat_to(c_new + WideW'(s8_b_q), DW);
    end else begin
      c_acc = c_new;
    end
  end

  logic [DW-1:0] s9_c_q;
  logic          s9_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s9_c_q    <= DW'(c_acc);
      s9_last_q <= s8_last_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[NStg-1];
  assign m_axis_tdata_o  = OutTdW'(s9_c_q);
  assign m_axis_tlast_o  = s9_last_q;

  // ---------------- assertions ----------------
  // an empty output register means nothing can hold the input back
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output stage");

  // an accepted input with no output taken adds one item in flight
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !(m_axis_tvalid_o && m_axis_tready_i))
    |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("item lost or duplicated in pipeline");

  // interpolated sigmoid stays between its two table points
  a_interp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy[2] && vld_q[1] && !s2_below_q && !s2_above_q)
    |=> (s3_s_q >= $past(s2_lo_q) && s3_s_q <= $past(s2_hi_q)))
    else $error("sigmoid interpolation out of segment");

endmodule

`default_nettype wire

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import silu_bwd_pkg::*;

  localparam int DW             = DataWidthDef;
  localparam int QF             = FracBits;
  localparam int SigDepth       = SigTableDepthDef;
  localparam int InW            = ((3*DW+7)/8)*8;
  localparam int OutW           = ((DW+7)/8)*8;
  localparam int LongHoldCycles = 400;
  localparam int TailCycles     = 30;
  localparam int PhaseItems     = 200;
  localparam longint unsigned EMinusOneQ30 = 64'd395007542;

  typedef enum int {RxAlways, RxRandom, RxPattern, RxSparse} rx_mode_e;

  typedef struct packed {
    logic [DW-1:0] grad;
    logic          last;
  } grad_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i = CfgAlphaGain;
  logic [GainWidth-1:0] cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InW-1:0]       s_axis_tdata_i = '0;   // x_value, grad_out, prev_grad, zero pad
  logic                 s_axis_tlast_i = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutW-1:0]      m_axis_tdata_o;        // grad_in, zero pad
  logic                 m_axis_tlast_o;

  // local copy of the gain registers
  logic signed [GainWidth-1:0] alpha_gain = AlphaGainRst;
  logic signed [GainWidth-1:0] beta_gain  = BetaGainRst;
  longint                      sig_lut [0:SigDepth];

  grad_result_t expected_grads[$];
  int           error_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  tx_gap_max = 0;
  rx_mode_e     rx_mode = RxAlways;
  bit           long_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  silu_backward_scaled_accumulate_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // sigmoid samples over [-8,8), Q0.16, plus a closing entry at +8
  initial begin : sigmoid_lut_init
    longint          d;
    longint          series;
    longint unsigned ad, a, ip, f, term, e, den, sp;
    for (int k = 0; k <= SigDepth; k++) begin
      d  = 16 * longint'(k) - 8 * longint'(SigDepth);
      ad = (d < 0) ? longint'(-d) : d;
      a  = (ad << 30) / SigDepth;
      ip = a >> 30;
      f  = a & 64'h3FFF_FFFF;
      series = longint'(1) <<< 30;
      term   = 64'd1 << 30;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * f) >> 30) / n;
        if (n % 2 == 1) begin
          series = series - longint'(term);
        end else begin
          series = series + longint'(term);
        end
      end
      e = series;
      for (longint unsigned i = 0; i < ip; i++) begin
        e = (e * EMinusOneQ30 + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + e;
      sp  = ((64'd1 << 46) + den / 2) / den;
      sig_lut[k] = (d < 0) ? 65536 - longint'(sp) : longint'(sp);
    end
  end

  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_q(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic [DW-1:0] predict_grad_in(input logic [DW-1:0] x_raw,
                                                    input logic [DW-1:0] dy_raw,
                                                    input logic [DW-1:0] prev_raw);
    longint x, dy, prev, u, pos, idx, fr, lo, hi, s, t, g, p, c;
    x  = longint'($signed(x_raw));
    dy = longint'($signed(dy_raw));
    u  = x + (longint'(8) <<< QF);
    if (u < 0) begin
      s = 0;
    end else if (u >= (longint'(16) <<< QF)) begin
      s = 65536;
    end else begin
      pos = u * SigDepth;
      idx = pos >>> 16;
      if (idx >= SigDepth) begin
        idx = SigDepth - 1;
      end
      fr = pos & 64'hFFFF;
      lo = sig_lut[idx];
      hi = sig_lut[idx + 1];
      if (hi < lo) begin
        hi = lo;
      end
      s = lo + (((hi - lo) * fr + 32768) >>> 16);
    end
    t = 65536 + round_q(x * (65536 - s), QF);
    g = clamp_q(round_q(s * t, 20));
    p = clamp_q(round_q(longint'(alpha_gain) * dy, QF));
    c = clamp_q(round_q(p * g, QF));
    // beta of zero: previous gradient not looked at
    if (beta_gain != 0) begin
      prev = longint'($signed(prev_raw));
      c = clamp_q(c + clamp_q(round_q(longint'(beta_gain) * prev, QF)));
    end
    return c[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] rand_q12();
    logic [DW-1:0] v;
    v = DW'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(DW-1){1'b0}}};
          1:       v = {1'b0, {(DW-1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = DW'($urandom_range(0, 16384)) - DW'(8192);  // within +-2.0
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_element(input logic [DW-1:0] x, input logic [DW-1:0] dy,
                              input logic [DW-1:0] prev, input logic last);
    int unsigned  gap;
    grad_result_t exp_item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InW'({prev, dy, x});
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    exp_item.grad = predict_grad_in(x, dy, prev);
    exp_item.last = last;
    expected_grads.push_back(exp_item);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input cfg_reg_e which, input logic [GainWidth-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= which;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (which == CfgAlphaGain) begin
      alpha_gain = value;
    end else begin
      beta_gain = value;
    end
  endtask

  // reset gains: alpha 1.0, beta 0, so prev_grad must have no effect
  task automatic test_extreme_elements();
    rx_mode    = RxAlways;
    tx_gap_max = 0;
    send_element(16'h8000, 16'h1000, 16'h7FFF, 1'b0);
    send_element(16'h7FFF, 16'h1000, 16'h8000, 1'b0);
    send_element(16'h0000, 16'h1000, 16'h0000, 1'b0);
    send_element(16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
    send_element(16'h0001, 16'h7FFF, 16'h8000, 1'b1);
    send_element(16'h1000, 16'h7FFF, 16'h1234, 1'b0);
    send_element(16'h5555, 16'hAAAA, 16'hFFFF, 1'b1);
    send_element(16'hAAAA, 16'h5555, 16'h0000, 1'b0);
  endtask

  task automatic test_gain_extremes();
    write_gain(CfgAlphaGain, 16'h7FFF);
    write_gain(CfgBetaGain, 16'h8000);
    send_element(16'h2000, 16'h7FFF, 16'h7FFF, 1'b0);
    send_element(16'h0000, 16'h8000, 16'h8000, 1'b1);
    send_element(16'hF000, 16'h0000, 16'h0001, 1'b0);
    send_element(16'hFFFF, 16'h0001, 16'h8000, 1'b0);
    write_gain(CfgAlphaGain, 16'h8000);
    write_gain(CfgBetaGain, 16'h7FFF);
    send_element(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
    send_element(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_element(16'h3000, 16'h0064, 16'h0000, 1'b0);
    send_element(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // alpha zero: the output is the scaled previous gradient alone
    write_gain(CfgAlphaGain, 16'h0000);
    write_gain(CfgBetaGain, 16'h1000);
    send_element(16'h1800, 16'h4000, 16'h8001, 1'b0);
    send_element(16'hE800, 16'hC000, 16'h7FFE, 1'b1);
  endtask

  task automatic test_random_buffers();
    logic [GainWidth-1:0] a;
    logic [GainWidth-1:0] b;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        a = 16'h7FFF;
      end else if ($urandom_range(0, 3) == 0) begin
        a = rand_q12();
      end else begin
        a = GainWidth'($urandom_range(0, 16384)) - GainWidth'(8192);
      end
      case (phase % 3)
        0:       b = '0;
        1:       b = rand_q12();
        default: b = GainWidth'($urandom_range(0, 8192)) - GainWidth'(4096);
      endcase
      write_gain(CfgAlphaGain, a);
      write_gain(CfgBetaGain, b);
      rx_mode    = rx_mode_e'(phase % 4);
      tx_gap_max = (phase % 2 == 0) ? 6 : ((phase == 3) ? 0 : 2);
      burst_left = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        send_element(rand_q12(), rand_q12(), rand_q12(), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // output held off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    write_gain(CfgAlphaGain, AlphaGainRst);
    write_gain(CfgBetaGain, 16'h0800);
    rx_mode       = RxAlways;
    tx_gap_max    = 0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_element(rand_q12(), rand_q12(), rand_q12(), i % 16 == 15);
    end
  endtask

  initial begin : result_ready_gen
    int unsigned hold_left;
    int unsigned beat;
    hold_left = 0;
    beat      = 0;
    forever begin
      @(posedge clk_i);
      beat++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways:  m_axis_tready_i <= 1'b1;
          RxRandom:  m_axis_tready_i <= ($urandom_range(0, 99) < 70);
          RxPattern: m_axis_tready_i <= ((beat % 13) < 7) || ((beat % 13) == 10);
          default:   m_axis_tready_i <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : grad_checker
    grad_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_grads.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata_o), 32'h0);
      end else begin
        want = expected_grads.pop_front();
        if (m_axis_tdata_o[DW-1:0] !== want.grad) begin
          report_mismatch("grad_in", 32'(m_axis_tdata_o[DW-1:0]), 32'(want.grad));
        end
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch("last_out", 32'(m_axis_tlast_o), 32'(want.last));
        end
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin : test_sequence
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_elements();
    test_gain_extremes();
    test_random_buffers();
    test_output_backpressure();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
